// ===== sv/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer package
// Shared constants, queue entry type and command classification codes.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int LINE_LENGTH = 16;
  localparam int POS_W       = $clog2(2 * LINE_LENGTH + 1);

  // Queue depth must be a power of two; the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int STEP_W      = 2;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_LINE2 = 8'hC0;

  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_LINE2,
    LEAD_CLEAR
  } lead_t;

  typedef struct packed {
    logic [7:0] char_code;
    lead_t      lead;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== sv/clcd_if.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer channels
// Valid/ready channels for incoming characters and outgoing bus strobes.
// ----------------------------------------------------------------------------
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] bus_nibble;
  logic       select_data;
  logic       last_strobe;

  modport source (output valid, output bus_nibble, output select_data,
                  output last_strobe, input ready);
  modport sink (input valid, input bus_nibble, input select_data,
                input last_strobe, output ready);
endinterface

// ===== sv/clcd_front.sv =====
// ----------------------------------------------------------------------------
// Character LCD front end
// Accepts characters, tracks the display position and classifies each item
// by the command that must precede it.
// ----------------------------------------------------------------------------
module clcd_front import clcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  clcd_in_if.sink   in_ch,
  input  qstat_t    qstat,
  output logic      push,
  output entry_t    push_entry
);

  logic [POS_W-1:0] position_r;
  logic [POS_W-1:0] position_nxt;
  lead_t            lead;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

  always_comb begin
    if (position_r == POS_W'(2 * LINE_LENGTH)) begin
      lead         = LEAD_CLEAR;
      position_nxt = POS_W'(1);
    end else if (position_r == POS_W'(LINE_LENGTH)) begin
      lead         = LEAD_LINE2;
      position_nxt = position_r + POS_W'(1);
    end else begin
      lead         = LEAD_NONE;
      position_nxt = position_r + POS_W'(1);
    end
  end

  assign push_entry.char_code = in_ch.char_code;
  assign push_entry.lead      = lead;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else if (push) begin
      position_r <= position_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= POS_W'(2 * LINE_LENGTH))
    else $error("display position beyond end of second line");
`endif

endmodule

// ===== sv/clcd_queue.sv =====
// ----------------------------------------------------------------------------
// Character LCD item queue
// Short register queue between the front end and the strobe sequencer.
// ----------------------------------------------------------------------------
module clcd_queue import clcd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output qstat_t qstat
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue pushed when full or popped when empty");
`endif

endmodule

// ===== sv/clcd_back.sv =====
// ----------------------------------------------------------------------------
// Character LCD strobe sequencer
// Splits the queued item into nibble strobes, the leading command first,
// and holds each strobe in an output register until it is taken.
// ----------------------------------------------------------------------------
module clcd_back import clcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  qstat_t    qstat,
  output logic      pop,
  clcd_out_if.source out_ch
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] eff_step;
  logic              advance;
  logic              head_valid;
  logic              last;
  logic [7:0]        byte_sel;
  logic [7:0]        cmd_byte;

  logic              out_valid_r;
  logic [3:0]        bus_nibble_r;
  logic              select_data_r;
  logic              last_strobe_r;

  assign head_valid = !qstat.empty;
  assign advance    = !out_valid_r || out_ch.ready;

  // A plain character skips the two command strobes.
  assign eff_step = step_r | {(head.lead == LEAD_NONE), 1'b0};
  assign last     = (eff_step == {STEP_W{1'b1}});
  assign pop      = advance && head_valid && last;
  assign step_nxt = last ? '0 : step_r + STEP_W'(1);

  always_comb begin
    unique case (head.lead)
      LEAD_CLEAR: cmd_byte = CMD_CLEAR;
      LEAD_LINE2: cmd_byte = CMD_LINE2;
      default:    cmd_byte = CMD_LINE2;
    endcase
  end

  assign byte_sel = eff_step[1] ? head.char_code : cmd_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      bus_nibble_r  <= eff_step[0] ? byte_sel[3:0] : byte_sel[7:4];
      select_data_r <= eff_step[1];
      last_strobe_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bus_nibble  = bus_nibble_r;
  assign out_ch.select_data = select_data_r;
  assign out_ch.last_strobe = last_strobe_r;

`ifndef NO_ASSERTIONS
  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_strobe_r |-> select_data_r)
    else $error("final strobe of an item is not character data");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> step_r == '0)
    else $error("sequencer mid-item with an empty queue");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && last_strobe_r)
    else $error("item released without its final strobe");
`endif

endmodule

// ===== sv/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer
// Turns character bytes into 4-bit bus strobes for a two-line display.
// ----------------------------------------------------------------------------
// The input channel carries one character byte per item. The output channel
// carries one enable strobe per item: the nibble, register select and a flag
// on the final strobe belonging to a character. Each character gives two
// strobes, high nibble first. At the end of the first line the line-two
// address command goes out first, and at the end of the display the clear
// command goes out first, each as two command strobes, making four in all.
// An accepted character is first written into the queue and then loaded as
// its first strobe into the output register. The sequencer issues one strobe
// per cycle while the receiver is ready; a two-entry queue lets the front
// end keep accepting while the sequencer works.
// Reset clears the position counter, the queue and the output valid flag.
// When the receiver stalls the output strobe holds, the queue fills and the
// input ready falls once both entries are in use.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer import clcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  clcd_in_if.sink    in_ch,
  clcd_out_if.source out_ch
);

  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;
  qstat_t qstat;

  clcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  clcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  clcd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
